>>> rtl/core/slpc_pkg.sv
// Shared constants, step codes, lane control type and log and exponent tables for the compressor.
package slpc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TD_W        = $clog2(TABLE_DEPTH);

  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 28;
  localparam int ENV_W    = 24;
  localparam int MANT_W   = 31;
  localparam int SHIFT_W  = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int LEVEL_FLOOR = -35840;
  localparam int DB_PER_OCT  = 394566;
  localparam int OCT_PER_DB  = 2786635;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO    = 3'd5;

  // Sequencer steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_PEAK  = 4'd1;
  localparam logic [STEP_W-1:0] ST_LOG   = 4'd2;
  localparam logic [STEP_W-1:0] ST_DBMUL = 4'd3;
  localparam logic [STEP_W-1:0] ST_OVER  = 4'd4;
  localparam logic [STEP_W-1:0] ST_TGT   = 4'd5;
  localparam logic [STEP_W-1:0] ST_ENV1  = 4'd6;
  localparam logic [STEP_W-1:0] ST_ENV2  = 4'd7;
  localparam logic [STEP_W-1:0] ST_ENV3  = 4'd8;
  localparam logic [STEP_W-1:0] ST_GAIN  = 4'd9;
  localparam logic [STEP_W-1:0] ST_EXP   = 4'd10;
  localparam logic [STEP_W-1:0] ST_MUL   = 4'd11;
  localparam logic [STEP_W-1:0] ST_RND   = 4'd12;
  localparam logic [STEP_W-1:0] ST_OUT   = 4'd13;

  typedef struct packed {
    logic load;
    logic mul;
    logic rnd;
  } lane_ctrl_t;

  typedef logic [15:0]       log_tab_t [TABLE_DEPTH];
  typedef logic [MANT_W-1:0] exp_tab_t [TABLE_DEPTH];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] rem;
    r     = '0;
    bit_v = 64'd1 << 62;
    rem   = v;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r   = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/TABLE_DEPTH) in Q0.16 by repeated squaring.
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] x;
    logic [15:0] r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      x = ((64'(TABLE_DEPTH) + 64'(i)) << 30) / 64'(TABLE_DEPTH);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          r[15-k] = 1'b1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  // 2^(j/TABLE_DEPTH) in Q1.30 from a product of square roots of two.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] q;
    logic [63:0] root;
    logic [63:0] m;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      q    = (64'(j) * 64'd65536) / 64'(TABLE_DEPTH);
      root = isqrt64(64'd1 << 61);
      m    = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        if (q[15-k]) begin
          m = (m * root) >> 30;
        end
        root = isqrt64(root << 30);
      end
      t[j] = m[MANT_W-1:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> rtl/core/slpc_lane.sv
// One channel lane: sample magnitude and application of the shared gain.
module slpc_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  slpc_pkg::lane_ctrl_t                ctrl_i,
  input  logic signed [slpc_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [slpc_pkg::MANT_W-1:0]         mant_i,
  input  logic [slpc_pkg::SHIFT_W-1:0]        shift_i,
  input  logic                                shift_ok_i,
  output logic [slpc_pkg::SAMPLE_W-1:0]       mag_o,
  output logic [slpc_pkg::OUT_W-1:0]          result_o,
  output logic                                clip_o
);

  localparam int PROD_W = slpc_pkg::SAMPLE_W + slpc_pkg::MANT_W;

  logic signed [slpc_pkg::SAMPLE_W-1:0] sample_q;
  logic [PROD_W-1:0]                    prod_q;
  logic [slpc_pkg::OUT_W-1:0]           result_q;
  logic                                 clip_q;
  logic [63:0]                          sum;
  logic [63:0]                          mag_out;
  logic [slpc_pkg::OUT_W-1:0]           result_d;

  assign mag_o = sample_q[slpc_pkg::SAMPLE_W-1] ? slpc_pkg::SAMPLE_W'(-sample_q)
                                                : slpc_pkg::SAMPLE_W'(sample_q);

  always_comb begin
    sum     = 64'(prod_q) + (64'd1 << (shift_i - 6'd1));
    mag_out = shift_ok_i ? (sum >> shift_i) : 64'd0;
    if (sample_q[slpc_pkg::SAMPLE_W-1]) begin
      if (mag_out > (64'd1 << 27)) begin
        result_d = {1'b1, {(slpc_pkg::OUT_W-1){1'b0}}};
      end else begin
        result_d = slpc_pkg::OUT_W'(-mag_out[slpc_pkg::OUT_W-1:0]);
      end
    end else begin
      if (mag_out > ((64'd1 << 27) - 64'd1)) begin
        result_d = {1'b0, {(slpc_pkg::OUT_W-1){1'b1}}};
      end else begin
        result_d = mag_out[slpc_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sample_q <= sample_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= PROD_W'(mag_o) * PROD_W'(mant_i);
    end
    if (ctrl_i.rnd) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (ctrl_i.rnd) begin
      clip_q <= (mag_out > (64'd1 << 23));
    end
  end

  assign result_o = result_q;
  assign clip_o   = clip_q;

endmodule

>>> rtl/core/slpc_env.sv
// Merge of the lane peaks, level detection, envelope smoothing and gain mantissa.
module slpc_env (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [slpc_pkg::STEP_W-1:0]         step_i,
  input  logic [slpc_pkg::SAMPLE_W-1:0]       mag_l_i,
  input  logic [slpc_pkg::SAMPLE_W-1:0]       mag_r_i,
  input  logic                                stereo_i,
  input  logic signed [14:0]                  threshold_i,
  input  logic [16:0]                         slope_i,
  input  logic [15:0]                         attack_i,
  input  logic [15:0]                         release_i,
  input  logic [12:0]                         makeup_i,
  output logic [slpc_pkg::ENV_W-1:0]          env_o,
  output logic [slpc_pkg::MANT_W-1:0]         mant_o,
  output logic [slpc_pkg::SHIFT_W-1:0]        shift_o,
  output logic                                shift_ok_o
);

  localparam int SCALE_W = slpc_pkg::SAMPLE_W + slpc_pkg::TD_W + 1;

  logic [slpc_pkg::SAMPLE_W-1:0] peak_q;
  logic                          zero_q;
  logic [20:0]                   dist_q;
  logic [39:0]                   prod_q;
  logic signed [17:0]            over_q;
  logic [slpc_pkg::ENV_W-1:0]    target_q;
  logic [15:0]                   coef_q;
  logic [39:0]                   p1_q;
  logic [40:0]                   p2_q;
  logic [slpc_pkg::ENV_W-1:0]    env_q;
  logic signed [25:0]            lg_q;
  logic [slpc_pkg::MANT_W-1:0]   mant_q;
  logic [slpc_pkg::SHIFT_W-1:0]  shift_q;
  logic                          shift_ok_q;

  logic [4:0]                    msb;
  logic [slpc_pkg::SAMPLE_W-1:0] frac;
  logic [SCALE_W-1:0]            scaled;
  logic [slpc_pkg::TD_W-1:0]     idx;
  logic [15:0]                   lvl_mag;
  logic signed [17:0]            level;
  logic [16:0]                   slope_eff;
  logic [33:0]                   tprod;
  logic [slpc_pkg::ENV_W-1:0]    target_d;
  logic [41:0]                   env_sum;
  logic signed [25:0]            gain_db;
  logic signed [49:0]            lgp;
  logic signed [9:0]             oct;
  logic [31:0]                   jprod;
  logic [slpc_pkg::TD_W-1:0]     jidx;
  logic signed [10:0]            shift_s;

  always_comb begin
    msb = '0;
    for (int b = 0; b < slpc_pkg::SAMPLE_W; b++) begin
      if (peak_q[b]) begin
        msb = 5'(b);
      end
    end
    frac   = peak_q - (slpc_pkg::SAMPLE_W'(1) << msb);
    scaled = (SCALE_W'(frac) * SCALE_W'(slpc_pkg::TABLE_DEPTH)) >> msb;
    idx    = scaled[slpc_pkg::TD_W-1:0];

    lvl_mag = 16'((prod_q + (40'd1 << 23)) >> 24);
    if (zero_q) begin
      level = 18'(slpc_pkg::LEVEL_FLOOR);
    end else begin
      level = -$signed({2'b00, lvl_mag});
    end
    if (level < 18'(slpc_pkg::LEVEL_FLOOR)) begin
      level = 18'(slpc_pkg::LEVEL_FLOOR);
    end

    slope_eff = (slope_i > 17'd65536) ? 17'd65536 : slope_i;
    tprod     = 34'(over_q[16:0]) * 34'(slope_eff);
    if (over_q > 18'sd0) begin
      target_d = ((tprod >> 8) > 34'hFFFFFF) ? 24'hFFFFFF : tprod[31:8];
    end else begin
      target_d = '0;
    end

    env_sum = 42'(p1_q) + 42'(p2_q) + 42'd32768;

    gain_db = $signed({5'b0, makeup_i, 8'b0}) - $signed({2'b00, env_q});
    lgp     = 50'(gain_db) * 50'(slpc_pkg::OCT_PER_DB);

    oct     = lg_q[25:16];
    jprod   = 32'(lg_q[15:0]) * 32'(slpc_pkg::TABLE_DEPTH);
    jidx    = jprod[16 +: slpc_pkg::TD_W];
    shift_s = 11'sd30 - 11'(oct);
  end

  always_ff @(posedge clk_i) begin
    case (step_i)
      slpc_pkg::ST_PEAK: begin
        peak_q <= (stereo_i && (mag_r_i > mag_l_i)) ? mag_r_i : mag_l_i;
        zero_q <= (stereo_i && (mag_r_i > mag_l_i)) ? (mag_r_i == '0) : (mag_l_i == '0);
      end
      slpc_pkg::ST_LOG: begin
        dist_q <= {5'd23 - msb, 16'd0} - 21'(slpc_pkg::LOG_TAB[idx]);
      end
      slpc_pkg::ST_DBMUL: begin
        prod_q <= 40'(dist_q) * 40'(slpc_pkg::DB_PER_OCT);
      end
      slpc_pkg::ST_OVER: begin
        over_q <= level - 18'(threshold_i);
      end
      slpc_pkg::ST_TGT: begin
        target_q <= target_d;
        coef_q   <= (target_d > env_q) ? attack_i : release_i;
      end
      slpc_pkg::ST_ENV1: begin
        p1_q <= 40'(coef_q) * 40'(env_q);
      end
      slpc_pkg::ST_ENV2: begin
        p2_q <= 41'(17'd65536 - {1'b0, coef_q}) * 41'(target_q);
      end
      slpc_pkg::ST_GAIN: begin
        lg_q <= lgp[49:24];
      end
      slpc_pkg::ST_EXP: begin
        mant_q     <= slpc_pkg::EXP_TAB[jidx];
        shift_q    <= shift_s[slpc_pkg::SHIFT_W-1:0];
        shift_ok_q <= (shift_s > 11'sd0) && (shift_s < 11'sd63);
      end
      default: begin
      end
    endcase
  end

  // The envelope is the only state that survives from item to item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (step_i == slpc_pkg::ST_ENV3) begin
      env_q <= env_sum[39:16];
    end
  end

  assign env_o      = env_q;
  assign mant_o     = mant_q;
  assign shift_o    = shift_q;
  assign shift_ok_o = shift_ok_q;

endmodule

>>> rtl/core/stereo_linked_peak_compressor.sv
// Top level of the stereo linked peak compressor: sequencer, registers, lanes and output stage.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  input    | in_valid_i / in_stall_o    | left_sample_i, right_sample_i
//  output   | out_valid_o / out_stall_i  | left_out_o, right_out_o, clip_flag_o,
//           |                            | gain_reduction_o
//  config   | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// An item runs through a fixed sequence of thirteen working steps after it is accepted,
// so a new item is taken only after the previous one has completed its last step.
// The step sequence is set by the chain of table lookups and multiplies in the envelope
// unit, each of which is registered. The finished result sits in an output register,
// so the next item is accepted while a result still waits to be taken; only a result
// that is still stalled when the next one is finished holds the sequencer.
// Reset clears the envelope to zero and loads the register defaults.
module stereo_linked_peak_compressor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [slpc_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [slpc_pkg::SAMPLE_W-1:0] right_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [slpc_pkg::OUT_W-1:0]    left_out_o,
  output logic signed [slpc_pkg::OUT_W-1:0]    right_out_o,
  output logic                                 clip_flag_o,
  output logic [13:0]                          gain_reduction_o,
  input  logic                                 cfg_we_i,
  input  logic [slpc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [slpc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // Configuration registers.
  logic signed [14:0] threshold_q;
  logic [16:0]        slope_q;
  logic [15:0]        attack_q;
  logic [15:0]        release_q;
  logic [12:0]        makeup_q;
  logic               stereo_q;

  // Sequencer.
  logic                        busy_q;
  logic [slpc_pkg::STEP_W-1:0] step_q;
  logic                        accept;
  logic                        finish;

  // Output stage.
  logic                       out_valid_q;
  logic [slpc_pkg::OUT_W-1:0] left_out_q;
  logic [slpc_pkg::OUT_W-1:0] right_out_q;
  logic                       clip_q;
  logic [13:0]                gr_q;

  slpc_pkg::lane_ctrl_t           lane_ctrl;
  logic [slpc_pkg::SAMPLE_W-1:0]  mag_l;
  logic [slpc_pkg::SAMPLE_W-1:0]  mag_r;
  logic [slpc_pkg::OUT_W-1:0]     res_l;
  logic [slpc_pkg::OUT_W-1:0]     res_r;
  logic                           clip_l;
  logic                           clip_r;
  logic [slpc_pkg::ENV_W-1:0]     env;
  logic [slpc_pkg::MANT_W-1:0]    mant;
  logic [slpc_pkg::SHIFT_W-1:0]   shift;
  logic                           shift_ok;
  logic [15:0]                    gr_raw;

  assign accept = in_valid_i && !busy_q;
  // The last step completes unless an earlier result is still waiting and stalled.
  assign finish = (step_q == slpc_pkg::ST_OUT) && !(out_valid_q && out_stall_i);

  assign lane_ctrl.load = accept;
  assign lane_ctrl.mul  = (step_q == slpc_pkg::ST_MUL);
  assign lane_ctrl.rnd  = (step_q == slpc_pkg::ST_RND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 15'sd256;
      slope_q     <= 17'd32768;
      attack_q    <= 16'd64047;
      release_q   <= 16'd65507;
      makeup_q    <= 13'd0;
      stereo_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slpc_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i[14:0];
        slpc_pkg::REG_SLOPE:     slope_q     <= cfg_data_i[16:0];
        slpc_pkg::REG_ATTACK:    attack_q    <= cfg_data_i[15:0];
        slpc_pkg::REG_RELEASE:   release_q   <= cfg_data_i[15:0];
        slpc_pkg::REG_MAKEUP:    makeup_q    <= cfg_data_i[12:0];
        slpc_pkg::REG_STEREO:    stereo_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= slpc_pkg::ST_IDLE;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= slpc_pkg::ST_PEAK;
    end else if (finish) begin
      busy_q <= 1'b0;
      step_q <= slpc_pkg::ST_IDLE;
    end else if (busy_q && (step_q != slpc_pkg::ST_OUT)) begin
      step_q <= step_q + 4'd1;
    end
  end

  slpc_lane u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .sample_i   (left_sample_i),
    .mant_i     (mant),
    .shift_i    (shift),
    .shift_ok_i (shift_ok),
    .mag_o      (mag_l),
    .result_o   (res_l),
    .clip_o     (clip_l)
  );

  slpc_lane u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .sample_i   (right_sample_i),
    .mant_i     (mant),
    .shift_i    (shift),
    .shift_ok_i (shift_ok),
    .mag_o      (mag_r),
    .result_o   (res_r),
    .clip_o     (clip_r)
  );

  slpc_env u_env (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_q),
    .mag_l_i     (mag_l),
    .mag_r_i     (mag_r),
    .stereo_i    (stereo_q),
    .threshold_i (threshold_q),
    .slope_i     (slope_q),
    .attack_i    (attack_q),
    .release_i   (release_q),
    .makeup_i    (makeup_q),
    .env_o       (env),
    .mant_o      (mant),
    .shift_o     (shift),
    .shift_ok_o  (shift_ok)
  );

  // The reduction meter shows whole 1/256 dB steps and saturates at its width.
  assign gr_raw = env[slpc_pkg::ENV_W-1:8];

  always_ff @(posedge clk_i) begin
    if (finish) begin
      left_out_q  <= res_l;
      right_out_q <= stereo_q ? res_r : '0;
      gr_q        <= (gr_raw > 16'd16383) ? 14'd16383 : gr_raw[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clip_q      <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
      clip_q      <= clip_l || (stereo_q && clip_r);
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o       = busy_q;
  assign out_valid_o      = out_valid_q;
  assign left_out_o       = left_out_q;
  assign right_out_o      = right_out_q;
  assign clip_flag_o      = clip_q;
  assign gain_reduction_o = gr_q;

  // An accepted item always starts at the first working step.
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (step_q == slpc_pkg::ST_PEAK))
    else $error("accepted item did not start the step sequence");

  // The sequencer only sits outside idle while an item is in flight.
  a_idle_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (step_q == slpc_pkg::ST_IDLE))
    else $error("step sequencer active without an item");

  // A finished item shows up as a valid result and frees the input.
  a_finish_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_o && !in_stall_o))
    else $error("finished item not presented on the output");

  // The sequencer never waits anywhere but on the last step.
  a_only_out_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && $past(busy_q) && !$past(accept) && $stable(step_q))
      |-> (step_q == slpc_pkg::ST_OUT))
    else $error("sequencer stalled in a working step");

endmodule
